// ===== hw/rtl/dpm_pkg.sv =====
// ----------------------------------------------------------------------------
// dpm_pkg: shared types and constants for the dither pattern mask
// Field widths, register indexes and pattern codes.
// ----------------------------------------------------------------------------
package dpm_pkg;

    localparam int COORD_W    = 12;  // pixel_x / pixel_y
    localparam int OFS_W      = 13;  // signed x / y offset
    localparam int SUM_W      = 14;  // coordinate plus offset, signed
    localparam int MAG_W      = 13;  // magnitude of the offset coordinate
    localparam int STEP_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int PAT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int REM_W      = STEP_W + 2;  // signed remainder and step arithmetic

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN = 3'd0,
        CFG_INVERT  = 3'd1,
        CFG_STEP    = 3'd2,
        CFG_X_OFS   = 3'd3,
        CFG_Y_OFS   = 3'd4,
        CFG_COLOR   = 3'd5
    } cfg_reg_t;

    typedef enum logic [PAT_W-1:0] {
        PAT_CHECKER    = 4'd0,
        PAT_CRISSCROSS = 4'd1,
        PAT_DIAG_DR    = 4'd2,
        PAT_DIAG_UR    = 4'd3,
        PAT_ROW        = 4'd4,
        PAT_COLUMN     = 4'd5,
        PAT_DOTS       = 4'd6,
        PAT_GRID       = 4'd7
    } pattern_t;

    // per-item flags that ride alongside the divider lanes
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic src;
    } side_t;

endpackage

// ===== hw/rtl/dither_pattern_mask.sv =====
// ----------------------------------------------------------------------------
// dither_pattern_mask: per-pixel dither decision for a masked blit
// Offsets the pixel position, divides by the step and tests the pattern.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one draw
// decision per pixel, in order. Each pixel passes the offset add and magnitude,
// captured at the transfer edge itself, then the pipelined restoring divide (one
// quotient bit per stage, both coordinates in parallel), then the pattern test
// into the output register. A stall on the output holds the whole pipeline,
// and in_ready drops with it. Write the configuration registers only while no
// pixel is in flight.
// ----------------------------------------------------------------------------
module dither_pattern_mask (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [dpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpm_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dpm_pkg::COORD_W-1:0]    pixel_x,
    input  logic [dpm_pkg::COORD_W-1:0]    pixel_y,
    input  logic                           source_set,
    // result output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           draw_pixel,
    output logic [dpm_pkg::COLOR_W-1:0]    pixel_color
);
    import dpm_pkg::*;

    localparam int DIV_STAGES = MAG_W;

    // configuration registers
    logic [PAT_W-1:0]         pattern_reg;
    logic                     invert_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [OFS_W-1:0]  x_ofs_reg;
    logic signed [OFS_W-1:0]  y_ofs_reg;
    logic [COLOR_W-1:0]       color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            invert_reg  <= 1'b0;
            step_reg    <= STEP_W'(1);
            x_ofs_reg   <= '0;
            y_ofs_reg   <= '0;
            color_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PATTERN: pattern_reg <= cfg_data[PAT_W-1:0];
                CFG_INVERT:  invert_reg  <= cfg_data[0];
                CFG_STEP:    step_reg    <= cfg_data[STEP_W-1:0];
                CFG_X_OFS:   x_ofs_reg   <= cfg_data;
                CFG_Y_OFS:   y_ofs_reg   <= cfg_data;
                CFG_COLOR:   color_reg   <= cfg_data[COLOR_W-1:0];
                default:     ;
            endcase
        end
    end

    logic [STEP_W-1:0] step_eff;
    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

    // whole pipeline moves together; it only holds when the output is stuck
    logic advance;
    logic out_valid_reg;
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // stage 1: offset add and sign-magnitude split
    logic signed [SUM_W-1:0] x_sum;
    logic signed [SUM_W-1:0] y_sum;
    logic [SUM_W-1:0]        x_abs;
    logic [SUM_W-1:0]        y_abs;

    assign x_sum = $signed({2'b00, pixel_x}) + SUM_W'(x_ofs_reg);
    assign y_sum = $signed({2'b00, pixel_y}) + SUM_W'(y_ofs_reg);
    assign x_abs = x_sum[SUM_W-1] ? (~x_sum + 1'b1) : x_sum;
    assign y_abs = y_sum[SUM_W-1] ? (~y_sum + 1'b1) : y_sum;

    logic              s1_valid_reg;
    logic [MAG_W-1:0]  s1_xmag_reg;
    logic [MAG_W-1:0]  s1_ymag_reg;
    side_t             s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_xmag_reg       <= x_abs[MAG_W-1:0];
            s1_ymag_reg       <= y_abs[MAG_W-1:0];
            s1_side_reg.x_neg <= x_sum[SUM_W-1];
            s1_side_reg.y_neg <= y_sum[SUM_W-1];
            s1_side_reg.src   <= source_set;
        end
    end

    // divide stages
    logic [STEP_W-1:0] x_rem;
    logic [STEP_W-1:0] y_rem;
    logic              x_qlsb;
    logic              y_qlsb;

    dpm_divider u_div_x (
        .clk       (clk),
        .en        (advance),
        .dividend  (s1_xmag_reg),
        .divisor   (step_eff),
        .remainder (x_rem),
        .quot_lsb  (x_qlsb)
    );

    dpm_divider u_div_y (
        .clk       (clk),
        .en        (advance),
        .dividend  (s1_ymag_reg),
        .divisor   (step_eff),
        .remainder (y_rem),
        .quot_lsb  (y_qlsb)
    );

    logic  vld_reg  [DIV_STAGES];
    side_t side_reg [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= s1_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= s1_side_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // pattern test; remainders take the sign of the coordinate
    side_t                    side_end;
    logic signed [REM_W-1:0]  xr;
    logic signed [REM_W-1:0]  yr;
    logic signed [REM_W-1:0]  step_s;
    logic                     x_zero;
    logic                     y_zero;
    logic                     diag_dr;
    logic                     diag_ur;
    logic                     anti;
    logic                     hit;
    logic                     allow;
    logic                     draw_next;

    assign side_end = side_reg[DIV_STAGES-1];
    assign step_s   = $signed({2'b00, step_eff});
    assign xr       = side_end.x_neg ? -$signed({2'b00, x_rem}) : $signed({2'b00, x_rem});
    assign yr       = side_end.y_neg ? -$signed({2'b00, y_rem}) : $signed({2'b00, y_rem});
    assign x_zero   = (x_rem == '0);
    assign y_zero   = (y_rem == '0);
    assign diag_dr  = (xr == yr);
    assign anti     = ((step_s - xr) == yr);
    assign diag_ur  = ((step_s - REM_W'(1) - xr) == yr);

    always_comb
    begin
        hit   = 1'b0;
        allow = 1'b1;
        unique case (pattern_t'(pattern_reg))
            PAT_CHECKER:    hit = x_qlsb ^ y_qlsb;  // negation keeps quotient parity
            PAT_CRISSCROSS: hit = diag_dr || anti;
            PAT_DIAG_DR:    hit = diag_dr;
            PAT_DIAG_UR:    hit = diag_ur;
            PAT_ROW:        hit = y_zero;
            PAT_COLUMN:     hit = x_zero;
            PAT_DOTS:       hit = x_zero && y_zero;
            PAT_GRID:       hit = x_zero || y_zero;
            default:        hit = 1'b1;
        endcase
        if (!pattern_reg[PAT_W-1])
        begin
            allow = hit ^ invert_reg;
        end
        else
        begin
            allow = 1'b1;
        end
    end

    assign draw_next = side_end.src && allow;

    // output register
    logic               draw_reg;
    logic [COLOR_W-1:0] color_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            draw_reg      <= draw_next;
            color_out_reg <= draw_next ? color_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign draw_pixel  = draw_reg;
    assign pixel_color = color_out_reg;

endmodule

// ===== hw/rtl/dpm_divider.sv =====
// ----------------------------------------------------------------------------
// dpm_divider: pipelined restoring divider, one quotient bit per stage
// Unsigned magnitude by step. Gives the remainder and the quotient LSB.
// ----------------------------------------------------------------------------
module dpm_divider (
    input  logic                        clk,
    input  logic                        en,
    input  logic [dpm_pkg::MAG_W-1:0]   dividend,
    input  logic [dpm_pkg::STEP_W-1:0]  divisor,
    output logic [dpm_pkg::STEP_W-1:0]  remainder,
    output logic                        quot_lsb
);
    import dpm_pkg::*;

    localparam int STEPS = MAG_W;

    logic [STEP_W-1:0] rem_reg [STEPS];
    logic [MAG_W-1:0]  dvd_reg [STEPS-1];
    logic              q_reg;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [STEP_W-1:0] rem_in;
        logic [MAG_W-1:0]  dvd_in;
        logic [STEP_W:0]   trial;
        logic [STEP_W:0]   diff;
        logic              ge;
        logic [STEP_W-1:0] rem_next;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dvd_in = dividend;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign dvd_in = dvd_reg[k-1];
        end

        assign trial    = {rem_in, dvd_in[MAG_W-1]};
        assign ge       = trial >= {1'b0, divisor};
        assign diff     = trial - {1'b0, divisor};
        // remainder stays below divisor, so eight bits hold it
        assign rem_next = ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
            end
        end

        if (k < STEPS - 1) begin : g_shift
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dvd_reg[k] <= {dvd_in[MAG_W-2:0], 1'b0};
                end
            end
        end
        else begin : g_last
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg <= ge;
                end
            end
        end
    end

    assign remainder = rem_reg[STEPS-1];
    assign quot_lsb  = q_reg;

endmodule

// ===== hw/rtl/dpm_checker.sv =====
// ----------------------------------------------------------------------------
// dpm_checker: port-level checks for the dither pattern mask
// Flow control and result consistency as seen on the top-level ports.
// ----------------------------------------------------------------------------
module dpm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           draw_pixel,
    input  logic [dpm_pkg::COLOR_W-1:0]    pixel_color
);

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    // a held result holds the whole pipeline
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // a stalled result keeps its value
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(draw_pixel)
            && $stable(pixel_color))
        else $error("stalled result changed");

    // no color without a draw
    a_color_needs_draw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !draw_pixel |-> pixel_color == '0)
        else $error("color set on a skipped pixel");

endmodule

bind dither_pattern_mask dpm_checker u_dpm_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for dither_pattern_mask
// Drives pixel transfers with random gaps and output back-pressure, predicts
// each draw decision from a local copy of the registers, and compares results
// in order. A short table of directed pixels is followed by random settings.
// ----------------------------------------------------------------------------
module tb_top;
    import dpm_pkg::*;

    localparam int RANDOM_PIXELS = 1300;
    localparam int DRAIN_CYCLES  = 20;

    // indexes with no register behind them, and the draw-all pattern codes
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B   = 3'd7;
    localparam logic [PAT_W-1:0]     PAT_ALL_FIRST = 4'd8;
    localparam logic [PAT_W-1:0]     PAT_ALL_LAST  = 4'd15;

    typedef struct packed {
        logic [PAT_W-1:0]        pat;
        logic                    inv;
        logic [STEP_W-1:0]       step;
        logic signed [OFS_W-1:0] xo;
        logic signed [OFS_W-1:0] yo;
        logic [COLOR_W-1:0]      color;
    } dither_cfg_t;

    typedef struct packed {
        logic               draw;
        logic [COLOR_W-1:0] color;
    } decision_t;

    typedef struct packed {
        dither_cfg_t          cfg;
        logic                 spare;   // also poke the unused indexes first
        logic [COORD_W-1:0]   px;
        logic [COORD_W-1:0]   py;
        logic                 src;
        logic                 typed;   // res holds the expected decision
        decision_t            res;
    } probe_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [COORD_W-1:0]    pixel_x;
    logic [COORD_W-1:0]    pixel_y;
    logic                  source_set;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  draw_pixel;
    logic [COLOR_W-1:0]    pixel_color;

    dither_cfg_t cur_cfg;
    decision_t   pending_decisions [$];
    bit          calm = 1'b0;
    int          n_fail = 0;
    int          n_pixels = 0;
    int          n_drawn = 0;
    int          n_settings = 0;

    localparam dither_cfg_t RESET_CFG = '{PAT_CHECKER, 1'b0, 8'd1, 13'sd0, 13'sd0, 8'd0};

    probe_t probes [0:17] = '{
        // reset values, checker of 1x1 cells
        '{RESET_CFG, 1'b0, 12'd0, 12'd0, 1'b1, 1'b1, '{1'b0, 8'h00}},
        '{RESET_CFG, 1'b0, 12'd1, 12'd0, 1'b1, 1'b1, '{1'b1, 8'h00}},
        // step of zero acts as one
        '{'{PAT_CHECKER, 1'b0, 8'd0, 13'sd0, 13'sd0, 8'h3C}, 1'b0,
          12'd4095, 12'd0, 1'b1, 1'b0, '0},
        // both coordinates pushed negative
        '{'{PAT_CHECKER, 1'b0, 8'd255, 13'sh1000, 13'sh1000, 8'h3C}, 1'b0,
          12'd0, 12'd4095, 1'b1, 1'b0, '0},
        '{'{PAT_CRISSCROSS, 1'b0, 8'd5, 13'sd0, 13'sd0, 8'h3C}, 1'b0,
          12'd3, 12'd2, 1'b1, 1'b0, '0},
        '{'{PAT_CRISSCROSS, 1'b1, 8'd255, 13'sd4095, 13'sd4095, 8'h3C}, 1'b0,
          12'd4095, 12'd4095, 1'b1, 1'b0, '0},
        '{'{PAT_DIAG_DR, 1'b0, 8'd4, 13'sd0, 13'sd0, 8'h3C}, 1'b0,
          12'd6, 12'd2, 1'b1, 1'b0, '0},
        '{'{PAT_DIAG_UR, 1'b0, 8'd4, -13'sd3, 13'sd0, 8'h3C}, 1'b0,
          12'd0, 12'd1, 1'b1, 1'b0, '0},
        '{'{PAT_ROW, 1'b0, 8'd3, 13'sd0, 13'sd0, 8'h3C}, 1'b0,
          12'd7, 12'd9, 1'b1, 1'b0, '0},
        // x lands on -1, negative remainder
        '{'{PAT_COLUMN, 1'b0, 8'd3, 13'sh1000, 13'sd0, 8'h3C}, 1'b0,
          12'd4095, 12'd0, 1'b1, 1'b0, '0},
        '{'{PAT_DOTS, 1'b0, 8'd8, 13'sd0, 13'sd0, 8'hFF}, 1'b0,
          12'd16, 12'd24, 1'b1, 1'b0, '0},
        '{'{PAT_GRID, 1'b1, 8'd8, 13'sd0, 13'sd0, 8'hFF}, 1'b0,
          12'd5, 12'd5, 1'b1, 1'b0, '0},
        '{'{PAT_GRID, 1'b0, 8'd0, 13'sd0, 13'sd0, 8'hFF}, 1'b0,
          12'd5, 12'd5, 1'b1, 1'b0, '0},
        // draw-all codes ignore the invert bit
        '{'{PAT_ALL_FIRST, 1'b1, 8'd4, 13'sd0, 13'sd0, 8'hA5}, 1'b0,
          12'd1, 12'd2, 1'b1, 1'b1, '{1'b1, 8'hA5}},
        '{'{PAT_ALL_LAST, 1'b0, 8'd4, 13'sd0, 13'sd0, 8'hFF}, 1'b0,
          12'd4095, 12'd4095, 1'b1, 1'b1, '{1'b1, 8'hFF}},
        '{'{PAT_ALL_LAST, 1'b0, 8'd4, 13'sd0, 13'sd0, 8'hFF}, 1'b0,
          12'd4095, 12'd4095, 1'b0, 1'b1, '{1'b0, 8'h00}},
        // clear source never draws
        '{'{PAT_CHECKER, 1'b0, 8'd1, 13'sd0, 13'sd0, 8'hFF}, 1'b0,
          12'd1, 12'd0, 1'b0, 1'b1, '{1'b0, 8'h00}},
        // writes to unused indexes change nothing
        '{'{PAT_CHECKER, 1'b0, 8'd1, 13'sd0, 13'sd0, 8'hFF}, 1'b1,
          12'd1, 12'd0, 1'b1, 1'b1, '{1'b1, 8'hFF}}
    };

    dither_pattern_mask dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .source_set  (source_set),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .draw_pixel  (draw_pixel),
        .pixel_color (pixel_color)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic decision_t dither_decision(input logic [COORD_W-1:0] px,
                                                  input logic [COORD_W-1:0] py,
                                                  input logic src);
        logic signed [SUM_W-1:0] xs;
        logic signed [SUM_W-1:0] ys;
        int        s;
        int        xr;
        int        yr;
        int        xq;
        int        yq;
        logic      hit;
        logic      known;
        decision_t d;
        xs = $signed({1'b0, px}) + $signed(cur_cfg.xo);
        ys = $signed({1'b0, py}) + $signed(cur_cfg.yo);
        s  = (cur_cfg.step == '0) ? 1 : int'(cur_cfg.step);
        // int division and remainder truncate toward zero
        xq = xs / s;
        yq = ys / s;
        xr = xs % s;
        yr = ys % s;
        known = 1'b1;
        case (cur_cfg.pat)
            PAT_CHECKER:    hit = ((xq ^ yq) & 1) != 0;
            PAT_CRISSCROSS: hit = (xr == yr) || ((s - xr) == yr);
            PAT_DIAG_DR:    hit = (xr == yr);
            PAT_DIAG_UR:    hit = ((s - 1) - xr) == yr;
            PAT_ROW:        hit = (yr == 0);
            PAT_COLUMN:     hit = (xr == 0);
            PAT_DOTS:       hit = (xr == 0) && (yr == 0);
            PAT_GRID:       hit = (xr == 0) || (yr == 0);
            default:
            begin
                hit   = 1'b1;
                known = 1'b0;
            end
        endcase
        if (known)
            hit = hit ^ cur_cfg.inv;
        d.draw  = src && hit;
        d.color = d.draw ? cur_cfg.color : '0;
        return d;
    endfunction

    function automatic logic signed [OFS_W-1:0] pick_offset();
        case ($urandom_range(9))
            0:       return 13'sh1000;
            1:       return 13'sd4095;
            2:       return '0;
            3, 4, 5: return 13'($urandom_range(32)) - 13'd16;
            default: return 13'($urandom());
        endcase
    endfunction

    // upper data bits beyond the register width are random junk
    function automatic logic [CFG_DATA_W-1:0] pad_junk(input logic [CFG_DATA_W-1:0] v,
                                                       input int w);
        logic [CFG_DATA_W-1:0] keep;
        keep = (13'd1 << w) - 13'd1;
        return (13'($urandom()) & ~keep) | (v & keep);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_PATTERN: cur_cfg.pat   = data[PAT_W-1:0];
            CFG_INVERT:  cur_cfg.inv   = data[0];
            CFG_STEP:    cur_cfg.step  = data[STEP_W-1:0];
            CFG_X_OFS:   cur_cfg.xo    = data;
            CFG_Y_OFS:   cur_cfg.yo    = data;
            CFG_COLOR:   cur_cfg.color = data[COLOR_W-1:0];
            default:     ;
        endcase
    endtask

    // every pixel yields one result, so an empty queue means nothing in flight
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(input dither_cfg_t c, input bit spare);
        wait_idle();
        if (spare)
        begin
            write_reg(CFG_SPARE_A, 13'($urandom()));
            write_reg(CFG_SPARE_B, '1);
        end
        write_reg(CFG_PATTERN, pad_junk(13'(c.pat), PAT_W));
        write_reg(CFG_INVERT, pad_junk(13'(c.inv), 1));
        write_reg(CFG_STEP, pad_junk(13'(c.step), STEP_W));
        write_reg(CFG_X_OFS, c.xo);
        write_reg(CFG_Y_OFS, c.yo);
        write_reg(CFG_COLOR, pad_junk(13'(c.color), COLOR_W));
        @(negedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                              input logic src, input decision_t want);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        pixel_x    <= px;
        pixel_y    <= py;
        source_set <= src;
        do
            @(posedge clk);
        while (!in_ready);
        pending_decisions.push_back(want);
        n_pixels++;
    endtask

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 18);

    always @(posedge clk)
    begin : result_check
        decision_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_decisions.size() == 0)
            begin
                $error("unexpected transfer: draw_pixel %0b pixel_color 0x%0h",
                       draw_pixel, pixel_color);
                n_fail++;
            end
            else
            begin
                want = pending_decisions.pop_front();
                if (draw_pixel !== want.draw)
                begin
                    $error("draw_pixel: expected %0b, got %0b", want.draw, draw_pixel);
                    n_fail++;
                end
                if (pixel_color !== want.color)
                begin
                    $error("pixel_color: expected 0x%0h, got 0x%0h", want.color, pixel_color);
                    n_fail++;
                end
                if (draw_pixel === 1'b1)
                    n_drawn++;
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("[dither_pattern_mask] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        dither_cfg_t        c;
        decision_t          want;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic               src;
        int                 r;
        int                 span;
        int                 rx;
        int                 ry;
        int                 phase;
        int                 sent;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        pixel_x    = '0;
        pixel_y    = '0;
        source_set = 1'b0;
        cur_cfg    = RESET_CFG;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (probes[i])
        begin
            if (probes[i].cfg != cur_cfg || probes[i].spare)
                write_settings(probes[i].cfg, probes[i].spare);
            want = probes[i].typed ? probes[i].res
                                   : dither_decision(probes[i].px, probes[i].py, probes[i].src);
            send_pixel(probes[i].px, probes[i].py, probes[i].src, want);
        end

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_PIXELS)
        begin
            // a few phases run at full rate on both sides
            calm = (phase >= 10 && phase < 14);
            r = $urandom_range(9);
            c.pat = (r < 8) ? 4'(r) : 4'($urandom_range(PAT_ALL_FIRST, PAT_ALL_LAST));
            c.inv = 1'($urandom_range(1));
            case ($urandom_range(9))
                0:          c.step = 8'd0;
                1:          c.step = 8'd255;
                2:          c.step = 8'd1;
                3, 4, 5, 6: c.step = 8'($urandom_range(2, 12));
                default:    c.step = 8'($urandom_range(255));
            endcase
            c.xo    = pick_offset();
            c.yo    = pick_offset();
            c.color = 8'($urandom());
            write_settings(c, $urandom_range(3) == 0);

            x0   = 12'($urandom());
            y0   = 12'($urandom());
            span = $urandom_range(4, 24);
            rx   = 0;
            ry   = 0;
            repeat ($urandom_range(35, 65))
            begin
                case ($urandom_range(9))
                    0:
                    begin
                        px = $urandom_range(1) ? '1 : '0;
                        py = $urandom_range(1) ? '1 : '0;
                    end
                    1, 2, 3, 4, 5:
                    begin
                        // small raster window so short periods show up
                        px = x0 + 12'(rx);
                        py = y0 + 12'(ry);
                        rx++;
                        if (rx == span)
                        begin
                            rx = 0;
                            ry++;
                        end
                    end
                    default:
                    begin
                        px = 12'($urandom());
                        py = 12'($urandom());
                    end
                endcase
                src = ($urandom_range(99) < 75);
                send_pixel(px, py, src, dither_decision(px, py, src));
                sent++;
            end
            phase++;
        end
        calm = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Pixels: %0d transferred, %0d drawn, across %0d register settings.",
                 n_pixels, n_drawn, n_settings);
        $display("Covered all eight patterns, draw-all codes, step 0/255 and offset extremes.");
        if (n_fail == 0)
            $display("[dither_pattern_mask] OK");
        else
            $display("[dither_pattern_mask] ERROR");
        $finish;
    end

endmodule
